// ----- hw/rtl/sohc_pkg.sv -----
// Package for the object hash catalog: status codes, FSM states, hash helper.
// No dependencies.
package sohc_pkg;
    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_UPDATED   = 3'd1;
    localparam logic [2:0] ST_REMOVED   = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HEAD,     // bucket head read back
        S_WALK,     // entry address / next read back
        S_RDPREV,   // read prev of head
        S_LINK1,    // remove: unlink write
        S_LINK2,    // insert: second link write
        S_TAKE,     // free stack next read back
        S_OUT
    } state_t;

    function automatic logic [31:0] fold32(input logic [31:0] a);
        fold32 = a ^ (a >> 8) ^ (a >> 16) ^ (a >> 24);
    endfunction
endpackage

// ----- hw/rtl/sohc_ram.sv -----
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module sohc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- hw/rtl/sync_object_hash_catalog.sv -----
// Object hash catalog top level: chained hash table with a free-slot stack.
// Uses sohc_pkg and sohc_ram.
//
// Steps: the bucket head is read, then the chain is walked entry by entry;
//   removal adds an unlink; an insert takes a free slot and writes the entry,
//   then the links if the bucket was not empty; a full pool ends at the take.
// Throughput: one transaction at a time; input reopens the cycle after the result
//   is taken; the chain walk through the entry memories (one read port) sets the rate.
// Reset: bucket valid bits, free stack and unused count clear at once; no
//   clearing pass, entry memories stay undefined until written.
module sync_object_hash_catalog #(
    parameter int BUCKETS = 64,
    parameter int ENTRIES = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // object_address[31:0], magic_word[63:32]
    input  logic        s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // status[2:0], slot_index[10:3], entry_magic[42:11], pad
    output logic        m_tuser    // unused marker, always 0
);
    import sohc_pkg::*;

    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int EW = $clog2(ENTRIES);
    localparam int CW = EW + 1;

    // bucket head memory: slot index; valid bits in flops
    logic [BUCKETS-1:0] bvalid_reg;
    logic          bh_we;
    logic [EW-1:0] bh_wdata, bh_rdata;
    logic [BW-1:0] bkt_reg;

    // entry memories
    logic          ea_we, em_we, en_we, ep_we;
    logic [EW-1:0] ea_waddr, em_waddr, en_waddr, ep_waddr, e_raddr;
    logic [EW-1:0] en_wdata, ep_wdata, en_rdata, ep_rdata;
    logic [31:0]   ea_rdata, em_rdata;

    state_t state_reg, state_next;
    logic          func_reg;
    logic [31:0]   addr_reg, magic_reg;
    logic [EW-1:0] head_reg, cur_reg, slot_reg, p_reg, n_reg;
    logic [CW-1:0] steps_reg, steps_next;
    logic          fs_valid_reg, fs_valid_next;
    logic [EW-1:0] fs_head_reg, fs_head_next;
    logic [CW-1:0] unused_reg, unused_next;
    logic [2:0]    status_reg;
    logic [31:0]   omagic_reg;
    logic [EW-1:0] head_next, cur_next, slot_next, p_next, n_next;
    logic [2:0]    status_next;
    logic [31:0]   omagic_next;
    logic          bv_set, bv_clr;
    logic [BW-1:0] bkt_in;
    logic [31:0]   fold_in;

    assign fold_in = fold32(s_tdata[31:0]);
    assign bkt_in  = (BUCKETS > 1) ? BW'(fold_in % BUCKETS) : '0;

    sohc_ram #(.WIDTH(EW), .DEPTH(BUCKETS)) u_bh (
        .clk(clk), .we(bh_we), .waddr(bkt_reg), .wdata(bh_wdata),
        .raddr(state_reg == S_IDLE ? bkt_in : bkt_reg), .rdata(bh_rdata));
    sohc_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_ea (
        .clk(clk), .we(ea_we), .waddr(ea_waddr), .wdata(addr_reg),
        .raddr(e_raddr), .rdata(ea_rdata));
    sohc_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_em (
        .clk(clk), .we(em_we), .waddr(em_waddr), .wdata(magic_reg),
        .raddr(e_raddr), .rdata(em_rdata));
    sohc_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_en (
        .clk(clk), .we(en_we), .waddr(en_waddr), .wdata(en_wdata),
        .raddr(e_raddr), .rdata(en_rdata));
    sohc_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_ep (
        .clk(clk), .we(ep_we), .waddr(ep_waddr), .wdata(ep_wdata),
        .raddr(e_raddr), .rdata(ep_rdata));

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {5'd0, omagic_reg, {(8 - EW > 0 ? 8 - EW : 0){1'b0}},
                       slot_reg[(EW > 8 ? 7 : EW - 1):0], status_reg};
    assign m_tuser  = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            bvalid_reg   <= '0;
            fs_valid_reg <= 1'b0;
            unused_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            fs_valid_reg <= fs_valid_next;
            unused_reg   <= unused_next;
            if (bv_set)
            begin
                bvalid_reg[bkt_reg] <= 1'b1;
            end
            else if (bv_clr)
            begin
                bvalid_reg[bkt_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && s_tvalid)
        begin
            func_reg  <= s_tuser;
            addr_reg  <= s_tdata[31:0];
            magic_reg <= s_tdata[63:32];
            bkt_reg   <= bkt_in;
        end
        head_reg    <= head_next;
        cur_reg     <= cur_next;
        slot_reg    <= slot_next;
        p_reg       <= p_next;
        n_reg       <= n_next;
        steps_reg   <= steps_next;
        fs_head_reg <= fs_head_next;
        status_reg  <= status_next;
        omagic_reg  <= omagic_next;
    end

    // Flow: HEAD reads head slot; WALK compares and follows next. On hit for
    // update: write magic. For delete: data of target already at WALK (n,p).
    // For insert: TAKE picks a slot, RDPREV reads prev of head and writes the entry, LINK2 links.
    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        cur_next     = cur_reg;
        slot_next    = slot_reg;
        p_next       = p_reg;
        n_next       = n_reg;
        steps_next   = steps_reg;
        fs_valid_next = fs_valid_reg;
        fs_head_next = fs_head_reg;
        unused_next  = unused_reg;
        status_next  = status_reg;
        omagic_next  = omagic_reg;
        e_raddr      = cur_reg;
        bh_we = 1'b0; bh_wdata = slot_reg;
        ea_we = 1'b0; ea_waddr = slot_reg;
        em_we = 1'b0; em_waddr = slot_reg;
        en_we = 1'b0; en_waddr = slot_reg; en_wdata = slot_reg;
        ep_we = 1'b0; ep_waddr = slot_reg; ep_wdata = slot_reg;
        bv_set = 1'b0; bv_clr = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                head_next  = bh_rdata;
                cur_next   = bh_rdata;
                e_raddr    = bh_rdata;
                steps_next = '0;
                if (bvalid_reg[bkt_reg])
                begin
                    state_next = S_WALK;
                end
                else if (func_reg)
                begin
                    status_next = ST_NOT_FOUND; slot_next = '0; omagic_next = '0;
                    state_next  = S_OUT;
                end
                else
                begin
                    e_raddr    = fs_head_reg;
                    state_next = S_TAKE;
                end
            end
            S_WALK:
            begin
                if (ea_rdata == addr_reg)
                begin
                    slot_next = cur_reg;
                    if (!func_reg)
                    begin
                        em_we = 1'b1; em_waddr = cur_reg;
                        status_next = ST_UPDATED; omagic_next = magic_reg;
                        state_next  = S_OUT;
                    end
                    else
                    begin
                        n_next = en_rdata; p_next = ep_rdata;
                        omagic_next = em_rdata; status_next = ST_REMOVED;
                        state_next  = S_LINK1;
                    end
                end
                else if (en_rdata == head_reg || steps_reg == CW'(ENTRIES - 1))
                begin
                    if (func_reg)
                    begin
                        status_next = ST_NOT_FOUND; slot_next = '0; omagic_next = '0;
                        state_next  = S_OUT;
                    end
                    else
                    begin
                        e_raddr    = fs_head_reg;
                        state_next = S_TAKE;
                    end
                end
                else
                begin
                    cur_next   = en_rdata;
                    e_raddr    = en_rdata;
                    steps_next = steps_reg + 1'b1;
                end
            end
            S_TAKE:
            begin
                e_raddr = head_reg;
                if (fs_valid_reg)
                begin
                    slot_next = fs_head_reg;
                    if (en_rdata == fs_head_reg)
                    begin
                        fs_valid_next = 1'b0;
                    end
                    else
                    begin
                        fs_head_next = en_rdata;
                    end
                    state_next = S_RDPREV;
                end
                else if (unused_reg < CW'(ENTRIES))
                begin
                    slot_next   = unused_reg[EW-1:0];
                    unused_next = unused_reg + 1'b1;
                    state_next  = S_RDPREV;
                end
                else
                begin
                    status_next = ST_FULL; slot_next = '0; omagic_next = '0;
                    state_next  = S_OUT;
                end
            end
            S_RDPREV:
            begin
                // insert: prev of head is valid now; write new entry
                status_next = ST_INSERTED; omagic_next = magic_reg;
                ea_we = 1'b1; em_we = 1'b1;
                bh_we = 1'b1; bv_set = 1'b1;
                if (bvalid_reg[bkt_reg])
                begin
                    p_next = ep_rdata;
                    en_we = 1'b1; en_wdata = head_reg;
                    ep_we = 1'b1; ep_wdata = ep_rdata;
                    state_next = S_LINK2;
                end
                else
                begin
                    en_we = 1'b1; ep_we = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_LINK2:
            begin
                // insert: next[p] = s, prev[h] = s
                en_we = 1'b1; en_waddr = p_reg; en_wdata = slot_reg;
                ep_we = 1'b1; ep_waddr = head_reg; ep_wdata = slot_reg;
                state_next = S_OUT;
            end
            S_LINK1:
            begin
                // remove: unlink, push slot onto free stack
                if (n_reg == slot_reg)
                begin
                    bv_clr = 1'b1;
                end
                else
                begin
                    en_we = 1'b1; en_waddr = p_reg; en_wdata = n_reg;
                    ep_we = 1'b1; ep_waddr = n_reg; ep_wdata = p_reg;
                    if (head_reg == slot_reg)
                    begin
                        bh_we = 1'b1; bh_wdata = n_reg;
                    end
                end
                fs_valid_next = 1'b1;
                fs_head_next  = slot_reg;
                // next[s] written on the output cycle below uses old stack head
                p_next = fs_valid_reg ? fs_head_reg : slot_reg;
                state_next = S_OUT;
                n_next = n_reg;
                cur_next = slot_reg;
                steps_next = '1;
            end
            S_OUT:
            begin
                if (func_reg && status_reg == ST_REMOVED && steps_reg == '1)
                begin
                    en_we = 1'b1; en_waddr = slot_reg; en_wdata = p_reg;
                    steps_next = '0;
                end
                if (m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready) else $error("accept during output");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(status_reg)))
        else $error("result dropped");
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (status_reg <= ST_FULL)) else $error("bad status");
    a_unused: assert property (@(posedge clk) disable iff (!rst_n)
        unused_reg <= CW'(ENTRIES)) else $error("unused count overflow");
endmodule

// ----- tb/sv/sohc_catalog_checker.sv -----
// Checker for the object hash catalog: watches both stream channels, predicts
// each result from a behavioral copy of the catalog and compares. Uses sohc_pkg.
module sohc_catalog_checker #(
    parameter int BUCKETS = 64,
    parameter int ENTRIES = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    input  logic        m_tuser,
    output int          fail_count,
    output int          pending
);
    import sohc_pkg::*;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  slot;
        logic [31:0] magic;
    } catalog_result_t;

    logic        bkt_valid [BUCKETS];
    logic [7:0]  bkt_head  [BUCKETS];
    logic [31:0] slot_addr [ENTRIES];
    logic [31:0] slot_magic[ENTRIES];
    logic [7:0]  slot_next [ENTRIES];
    logic [7:0]  slot_prev [ENTRIES];
    logic        free_valid;
    logic [7:0]  free_top;
    int          fresh_count;

    catalog_result_t expected_results[$];

    assign pending = expected_results.size();

    function automatic bit find_in_chain(int b, logic [31:0] a, output logic [7:0] hit);
        logic [7:0] h;
        logic [7:0] s;
        h = bkt_head[b];
        s = h;
        hit = 0;
        for (int k = 0; k < ENTRIES; k++)
        begin
            if (slot_addr[s] == a)
            begin
                hit = s;
                return 1;
            end
            s = slot_next[s];
            if (s == h)
                break;
        end
        return 0;
    endfunction

    function automatic catalog_result_t apply_item(logic dereg, logic [31:0] a,
                                                   logic [31:0] m);
        catalog_result_t r;
        int b;
        logic [7:0] s, h, p, n;
        bit found, got;
        b = int'(fold32(a) % BUCKETS);
        r = '0;
        found = bkt_valid[b] && find_in_chain(b, a, s);
        if (!dereg)
        begin
            if (found)
            begin
                slot_magic[s] = m;
                r = '{ST_UPDATED, s, m};
            end
            else
            begin
                got = 1;
                if (free_valid)
                begin
                    s = free_top;
                    if (slot_next[s] == s)
                        free_valid = 0;
                    else
                        free_top = slot_next[s];
                end
                else if (fresh_count < ENTRIES)
                begin
                    s = fresh_count[7:0];
                    fresh_count++;
                end
                else
                    got = 0;
                if (!got)
                    r = '{ST_FULL, 8'd0, 32'd0};
                else
                begin
                    if (bkt_valid[b])
                    begin
                        h = bkt_head[b];
                        p = slot_prev[h];
                        slot_next[s] = h;
                        slot_prev[s] = p;
                        slot_next[p] = s;
                        slot_prev[h] = s;
                    end
                    else
                    begin
                        slot_next[s] = s;
                        slot_prev[s] = s;
                        bkt_valid[b] = 1;
                    end
                    bkt_head[b] = s;
                    slot_addr[s] = a;
                    slot_magic[s] = m;
                    r = '{ST_INSERTED, s, m};
                end
            end
        end
        else if (!found)
            r = '{ST_NOT_FOUND, 8'd0, 32'd0};
        else
        begin
            n = slot_next[s];
            p = slot_prev[s];
            if (n == s)
            begin
                bkt_valid[b] = 0;
                bkt_head[b] = 0;
            end
            else
            begin
                slot_next[p] = n;
                slot_prev[n] = p;
                if (bkt_head[b] == s)
                    bkt_head[b] = n;
            end
            slot_next[s] = free_valid ? free_top : s;
            free_top = s;
            free_valid = 1;
            r = '{ST_REMOVED, s, slot_magic[s]};
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        catalog_result_t exp_r;
        catalog_result_t got_r;
        if (!rst_n)
        begin
            for (int i = 0; i < BUCKETS; i++)
            begin
                bkt_valid[i] = 0;
                bkt_head[i] = 0;
            end
            for (int i = 0; i < ENTRIES; i++)
            begin
                slot_addr[i] = 0;
                slot_magic[i] = 0;
                slot_next[i] = 0;
                slot_prev[i] = 0;
            end
            free_valid = 0;
            free_top = 0;
            fresh_count = 0;
            fail_count = 0;
            expected_results.delete();
        end
        else
        begin
            // result side first: a result can never answer the item taken this edge
            if (m_tvalid && m_tready)
            begin
                // bus order is status low, slot, magic high; struct order is reversed
                got_r = {m_tdata[2:0], m_tdata[10:3], m_tdata[42:11]};
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch: unexpected result %h", got_r);
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (got_r.status !== exp_r.status || got_r.slot !== exp_r.slot
                        || got_r.magic !== exp_r.magic || m_tuser !== 1'b0)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: status %0d/%0d slot %0d/%0d magic %h/%h",
                                     exp_r.status, got_r.status, exp_r.slot, got_r.slot,
                                     exp_r.magic, got_r.magic);
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(apply_item(s_tuser, s_tdata[31:0],
                                                      s_tdata[63:32]));
        end
    end
endmodule

// ----- tb/sv/tb_top.sv -----
// Top of the object hash catalog testbench: clock, reset, stimulus, verdict.
// Depends on sohc_pkg, sync_object_hash_catalog and sohc_catalog_checker.
module tb_top;
    logic        clk = 0;
    logic        rst_n = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        s_tuser = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [47:0] m_tdata;
    logic        m_tuser;
    int          fail_count;
    int          pending;
    int          idle_cycles = 0;
    bit          quiet = 0;     // no idling in the closing stretch
    bit          done = 0;

    // Recently registered addresses, reused to hit updates and removals.
    logic [31:0] known_addrs[$];

    localparam int WATCHDOG = 20000;

    always #4 clk = ~clk;

    sync_object_hash_catalog uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    sohc_catalog_checker chk (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .fail_count(fail_count), .pending(pending)
    );

    // Receiver: ready toggles in bursts of stall and flow.
    initial
    begin
        int run;
        @(posedge rst_n);
        forever
        begin
            run = $urandom_range(1, 12);
            m_tready <= quiet ? 1'b1 : ($urandom_range(0, 2) != 0);
            repeat (run) @(posedge clk);
        end
    end

    // Watchdog: cycles with no transaction on either side.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG && !done)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // One transaction: hold valid until it is taken; optional idle burst first.
    task automatic send_item(logic dereg, logic [31:0] a, logic [31:0] m);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        s_tvalid <= 1;
        s_tuser  <= dereg;
        s_tdata  <= {m, a};
        do @(posedge clk); while (!s_tready);
        if (!dereg)
        begin
            known_addrs.push_back(a);
            if (known_addrs.size() > 40)
                void'(known_addrs.pop_front());
        end
    endtask

    function automatic logic [31:0] pick_addr();
        int k;
        k = $urandom_range(0, 9);
        if (k < 5 && known_addrs.size() > 0)
            return known_addrs[$urandom_range(0, known_addrs.size() - 1)];
        if (k < 8)
            return {24'h0, 8'($urandom)} ^ {2'($urandom_range(0, 3)), 30'h0};
        return $urandom;
    endfunction

    task automatic wait_drained();
        s_tvalid <= 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: removal from empty, field extremes, same bucket chain
        // (0x00 and 0x0101 fold alike), update, middle and head removal, and
        // free stack reuse with its self-linked bottom.
        send_item(1'b1, 32'h0, 32'h0);
        send_item(1'b0, 32'h0, 32'h8000_0000);
        send_item(1'b0, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        send_item(1'b0, 32'h0000_0101, 32'hFFFF_FFFF);
        send_item(1'b0, 32'h0001_0001, 32'h1234_5678);
        send_item(1'b0, 32'h0000_0101, 32'h0000_0001);
        send_item(1'b1, 32'h0000_0101, 32'h0);
        send_item(1'b1, 32'h0001_0001, 32'h0);
        send_item(1'b1, 32'h0000_0101, 32'h0);
        send_item(1'b0, 32'hAAAA_5555, 32'h5555_AAAA);
        send_item(1'b0, 32'h5555_AAAA, 32'hAAAA_5555);
        send_item(1'b1, 32'h0, 32'hFFFF_FFFF);
        send_item(1'b1, 32'hFFFF_FFFF, 32'h0);
        send_item(1'b0, 32'h0000_0101, 32'h0);
        send_item(1'b0, 32'h0001_0001, 32'h1);
        send_item(1'b0, 32'h8000_0000, 32'h8000_0001);

        // Pressure: hold off until every result is back.
        wait_drained();

        // Fill the pool to hit the full case, then probe it and drain a bit.
        for (int i = 0; i < 260; i++)
            send_item(1'b0, 32'h1000_0000 + i * 32'h0001_0003, $urandom);
        send_item(1'b0, 32'hDEAD_BEEF, 32'h1);
        send_item(1'b0, 32'h1000_0000, 32'h2);
        for (int i = 0; i < 200; i++)
            send_item(1'b1, 32'h1000_0000 + $urandom_range(0, 259) * 32'h0001_0003,
                      $urandom);

        // Random mix.
        for (int i = 0; i < 1050; i++)
        begin
            if (i == 900)
                quiet = 1;
            send_item($urandom_range(0, 2) == 0, pick_addr(), $urandom);
        end

        s_tvalid <= 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        done = 1;
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

// ----- files.f -----
hw/rtl/sohc_pkg.sv
hw/rtl/sohc_ram.sv
hw/rtl/sync_object_hash_catalog.sv
tb/sv/sohc_catalog_checker.sv
tb/sv/tb_top.sv
